// File: hdl/page_mapping_cam_table_assert.svh
// Assertion macros for the page mapping table.
// Used by the top level only; clock i_clk and active-low reset i_rst_n are implied.
`ifndef PAGE_MAPPING_CAM_TABLE_ASSERT_SVH
`define PAGE_MAPPING_CAM_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define PMCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PMCT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PMCT_ASSERT_IMP(lbl, ante, cons, msg)
`define PMCT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: hdl/pmct_pkg.sv
// Shared types and constants for the page mapping table.
// No dependencies; used by every module of the block.
package pmct_pkg;

    // Number of mapping entries, one cell each.
    localparam int ENTRIES = 16;

    typedef enum logic [1:0] {
        MODE_INSERT    = 2'd0,
        MODE_FIND_KEY  = 2'd1,
        MODE_FIND_PHYS = 2'd2,
        MODE_REMOVE    = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] section_key;
        logic [31:0] phys_addr;
        logic [31:0] virt_addr;
        logic [31:0] page_offset;
        logic [31:0] page_length;
    } t_in_item;

    typedef struct packed {
        logic        success;
        logic [3:0]  slot_index;
        logic [15:0] hit_section;
        logic [31:0] hit_phys;
        logic [31:0] hit_virt;
        logic [31:0] hit_offset;
        logic [31:0] hit_length;
    } t_out_item;

    // Item traveling down the row of cells: request plus result so far.
    typedef struct packed {
        logic      vld;
        t_in_item  req;
        t_out_item res;
    } t_pkt;

endpackage

// File: hdl/pmct_cell.sv
// One table entry of the page mapping table plus its stage of the item chain.
// Depends on pmct_pkg.
module pmct_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic [3:0]    i_slot,
    input  pmct_pkg::t_pkt i_pkt,
    output pmct_pkg::t_pkt o_pkt
);

    logic [15:0]    r_sec;
    logic [31:0]    r_pa;
    logic [31:0]    r_va;
    logic [31:0]    r_off;
    logic [31:0]    r_len;
    logic           r_vld;
    pmct_pkg::t_pkt r_pkt;
    pmct_pkg::t_pkt n_pkt;
    logic           w_key_ok;
    logic           w_hit_ins;
    logic           w_hit_key;
    logic           w_hit_pa;
    logic           w_take;

    // Match this entry against the passing item.
    always_comb begin
        w_key_ok  = (i_pkt.req.section_key != 16'd0);
        w_hit_ins = (i_pkt.req.mode == pmct_pkg::MODE_INSERT) && w_key_ok && (r_sec == 16'd0);
        w_hit_key = ((i_pkt.req.mode == pmct_pkg::MODE_FIND_KEY) ||
                     (i_pkt.req.mode == pmct_pkg::MODE_REMOVE)) && w_key_ok &&
                    (r_sec == i_pkt.req.section_key) && (r_off == i_pkt.req.page_offset);
        w_hit_pa  = (i_pkt.req.mode == pmct_pkg::MODE_FIND_PHYS) && (r_sec != 16'd0) &&
                    (r_pa == i_pkt.req.phys_addr);
        w_take    = i_pkt.vld && !i_pkt.res.success && (w_hit_ins || w_hit_key || w_hit_pa);
    end

    // Claim the item: lower cells already passed on it, so first claim wins.
    always_comb begin
        n_pkt = i_pkt;
        if (w_take) begin
            n_pkt.res.success    = 1'b1;
            n_pkt.res.slot_index = i_slot;
            if (w_hit_ins) begin
                n_pkt.res.hit_section = i_pkt.req.section_key;
                n_pkt.res.hit_phys    = i_pkt.req.phys_addr;
                n_pkt.res.hit_virt    = i_pkt.req.virt_addr;
                n_pkt.res.hit_offset  = i_pkt.req.page_offset;
                n_pkt.res.hit_length  = i_pkt.req.page_length;
            end else begin
                n_pkt.res.hit_section = r_sec;
                n_pkt.res.hit_phys    = r_pa;
                n_pkt.res.hit_virt    = r_va;
                n_pkt.res.hit_offset  = r_off;
                n_pkt.res.hit_length  = r_len;
            end
        end
    end

    // Update the entry: fill on insert, free on remove.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec <= 16'd0;
        end else if (i_adv && w_take) begin
            if (w_hit_ins) begin
                r_sec <= i_pkt.req.section_key;
            end else if (i_pkt.req.mode == pmct_pkg::MODE_REMOVE) begin
                r_sec <= 16'd0;
            end
        end
    end

    // Entry payload only matters while the entry is occupied.
    always_ff @(posedge i_clk) begin
        if (i_adv && w_hit_ins && w_take) begin
            r_pa  <= i_pkt.req.phys_addr;
            r_va  <= i_pkt.req.virt_addr;
            r_off <= i_pkt.req.page_offset;
            r_len <= i_pkt.req.page_length;
        end
    end

    // Advance the item to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= n_pkt.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pkt <= n_pkt;
        end
    end

    always_comb begin
        o_pkt     = r_pkt;
        o_pkt.vld = r_vld;
    end

endmodule

// File: hdl/pmct_out.sv
// Output register of the page mapping table: zeroes failed results, holds on stall.
// Depends on pmct_pkg.
module pmct_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pmct_pkg::t_pkt     i_pkt,
    input  logic               i_out_stall,
    output logic               o_adv,
    output logic               o_out_valid,
    output pmct_pkg::t_out_item o_out_item
);

    logic                r_vld;
    pmct_pkg::t_out_item r_item;

    // Move the chain whenever the output register is free or being drained.
    assign o_adv = !r_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_adv) begin
            r_vld <= i_pkt.vld;
        end
    end

    // Drop all fields of a failed operation to zero.
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_item <= i_pkt.res.success ? i_pkt.res : '0;
        end
    end

    assign o_out_valid = r_vld;
    assign o_out_item  = r_item;

endmodule

// File: hdl/page_mapping_cam_table.sv
// Page mapping table: a row of ENTRIES cells, each holding one mapping.
// An accepted item is registered in the first cell, then in each further cell in turn, and
// last in the output register; one item per cycle is accepted while the output does not
// stall, since each item steps one cell per cycle and the row is fully pipelined.
// The whole row freezes while a result waits under stall.
// Reset (synchronous, active low) frees every entry and empties the chain at once.
`include "page_mapping_cam_table_assert.svh"
module page_mapping_cam_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pmct_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pmct_pkg::t_out_item o_out_item
);

    pmct_pkg::t_pkt w_chain [0:pmct_pkg::ENTRIES];
    logic           w_adv;

    // Launch a new item into the first cell.
    always_comb begin
        w_chain[0]     = '0;
        w_chain[0].vld = i_in_valid;
        w_chain[0].req = i_in_item;
    end

    assign o_in_stall = !w_adv;

    // Row of entry cells.
    for (genvar g = 0; g < pmct_pkg::ENTRIES; g++) begin : g_cell
        pmct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_slot  (4'(g)),
            .i_pkt   (w_chain[g]),
            .o_pkt   (w_chain[g+1])
        );
    end

    pmct_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt       (w_chain[pmct_pkg::ENTRIES]),
        .i_out_stall (i_out_stall),
        .o_adv       (w_adv),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // Checks.
    `PMCT_ASSERT_IMP(a_fail_zero, o_out_valid && !o_out_item.success, o_out_item.slot_index == 4'd0 && o_out_item.hit_section == 16'd0, "failed result carries nonzero fields")
    `PMCT_ASSERT_IMP(a_hit_occupied, o_out_valid && o_out_item.success, o_out_item.hit_section != 16'd0, "successful result names a free entry")
    `PMCT_ASSERT_IMP(a_stall_back, o_out_valid && i_out_stall, o_in_stall, "input taken while result held")
    `PMCT_ASSERT_NXT(a_no_ghost, !w_chain[pmct_pkg::ENTRIES].vld && !(o_out_valid && i_out_stall), !o_out_valid, "result appeared without an item")

endmodule
